// File: rtl/cod_pkg.sv
// ----------------------------------------------------------------------------
// cod_pkg
// Shared types and constants for the opcode decoder: operation classes,
// fixed opcode values and the decoded record that travels between modules.
// ----------------------------------------------------------------------------
package cod_pkg;

	// Fixed opcode values that get a decoding of their own.
	localparam logic [7:0] OPC_HALT   = 8'h76;
	localparam logic [7:0] OPC_PREFIX = 8'hCB;

	typedef enum logic [5:0] {
		OP_NOP            = 6'd0,
		OP_STOP           = 6'd1,
		OP_HALT           = 6'd2,
		OP_LD_R16_IMM16   = 6'd3,
		OP_LD_MEM16_A     = 6'd4,
		OP_LD_A_MEM16     = 6'd5,
		OP_LD_IMM16MEM_SP = 6'd6,
		OP_INC_R16        = 6'd7,
		OP_DEC_R16        = 6'd8,
		OP_ADD_HL_R16     = 6'd9,
		OP_INC_R8         = 6'd10,
		OP_DEC_R8         = 6'd11,
		OP_LD_R8_IMM8     = 6'd12,
		OP_RLCA           = 6'd13,
		OP_RRCA           = 6'd14,
		OP_RLA            = 6'd15,
		OP_RRA            = 6'd16,
		OP_DAA            = 6'd17,
		OP_CPL            = 6'd18,
		OP_SCF            = 6'd19,
		OP_CCF            = 6'd20,
		OP_JR             = 6'd21,
		OP_JR_COND        = 6'd22,
		OP_LD_R8_R8       = 6'd23,
		OP_ALU_A_R8       = 6'd24,
		OP_ALU_A_IMM8     = 6'd25,
		OP_RET_COND       = 6'd26,
		OP_RET            = 6'd27,
		OP_RETI           = 6'd28,
		OP_JP_COND        = 6'd29,
		OP_JP             = 6'd30,
		OP_JP_HL          = 6'd31,
		OP_CALL_COND      = 6'd32,
		OP_CALL           = 6'd33,
		OP_RST            = 6'd34,
		OP_POP            = 6'd35,
		OP_PUSH           = 6'd36,
		OP_PREFIX         = 6'd37,
		OP_LDH_C_A        = 6'd38,
		OP_LDH_IMM8_A     = 6'd39,
		OP_LD_IMM16_A     = 6'd40,
		OP_LDH_A_C        = 6'd41,
		OP_LDH_A_IMM8     = 6'd42,
		OP_LD_A_IMM16     = 6'd43,
		OP_ADD_SP_E8      = 6'd44,
		OP_LD_HL_SP_E8    = 6'd45,
		OP_LD_SP_HL       = 6'd46,
		OP_DI             = 6'd47,
		OP_EI             = 6'd48,
		OP_SHIFT          = 6'd49,
		OP_BIT            = 6'd50,
		OP_RES            = 6'd51,
		OP_SET            = 6'd52,
		OP_ILLEGAL        = 6'd53
	} cod_class_t;

	typedef struct packed {
		cod_class_t  op_class;
		logic [2:0]  alu_kind;
		logic [2:0]  dst_code;
		logic [2:0]  src_code;
		logic [1:0]  pair_code;
		logic [1:0]  cond_code;
		logic [2:0]  bit_number;
		logic [5:0]  restart_vector;
		logic [1:0]  imm_bytes;
		logic        illegal;
	} cod_rec_t;

endpackage

// File: rtl/cod_decode.sv
// ----------------------------------------------------------------------------
// cod_decode
// Combinational decode of one opcode byte, plain or after the prefix byte,
// into the decoded record. Fields that a class does not use stay zero.
// ----------------------------------------------------------------------------
module cod_decode
	import cod_pkg::*;
(
	input  logic [7:0] opcode,
	input  logic       after_prefix,
	output cod_rec_t   rec
);

	logic [2:0] r_field;
	logic [1:0] p_field;
	logic [2:0] z_field;

	assign r_field = opcode[5:3];
	assign p_field = opcode[5:4];
	assign z_field = opcode[2:0];

	always_comb begin
		rec          = '0;
		rec.op_class = OP_NOP;
		if (after_prefix) begin
			case (opcode[7:6])
				2'd0: begin
					rec.op_class = OP_SHIFT;
					rec.alu_kind = r_field;
					rec.dst_code = z_field;
				end
				2'd1: begin
					rec.op_class   = OP_BIT;
					rec.bit_number = r_field;
					rec.src_code   = z_field;
				end
				2'd2: begin
					rec.op_class   = OP_RES;
					rec.bit_number = r_field;
					rec.dst_code   = z_field;
				end
				default: begin
					rec.op_class   = OP_SET;
					rec.bit_number = r_field;
					rec.dst_code   = z_field;
				end
			endcase
		end else begin
			case (opcode[7:6])
				2'd0: begin
					case (opcode)
						8'h00: rec.op_class = OP_NOP;
						8'h08: begin
							rec.op_class  = OP_LD_IMM16MEM_SP;
							rec.imm_bytes = 2'd2;
						end
						// STOP is followed by one padding byte.
						8'h10: begin
							rec.op_class  = OP_STOP;
							rec.imm_bytes = 2'd1;
						end
						8'h18: begin
							rec.op_class  = OP_JR;
							rec.imm_bytes = 2'd1;
						end
						8'h07: rec.op_class = OP_RLCA;
						8'h0F: rec.op_class = OP_RRCA;
						8'h17: rec.op_class = OP_RLA;
						8'h1F: rec.op_class = OP_RRA;
						8'h27: rec.op_class = OP_DAA;
						8'h2F: rec.op_class = OP_CPL;
						8'h37: rec.op_class = OP_SCF;
						8'h3F: rec.op_class = OP_CCF;
						default: begin
							case (opcode[3:0])
								4'h1: begin
									rec.op_class  = OP_LD_R16_IMM16;
									rec.imm_bytes = 2'd2;
									rec.pair_code = p_field;
								end
								4'h2: begin
									rec.op_class  = OP_LD_MEM16_A;
									rec.pair_code = p_field;
								end
								4'hA: begin
									rec.op_class  = OP_LD_A_MEM16;
									rec.pair_code = p_field;
								end
								4'h3: begin
									rec.op_class  = OP_INC_R16;
									rec.pair_code = p_field;
								end
								4'hB: begin
									rec.op_class  = OP_DEC_R16;
									rec.pair_code = p_field;
								end
								4'h9: begin
									rec.op_class  = OP_ADD_HL_R16;
									rec.pair_code = p_field;
								end
								default: begin
									case (z_field)
										3'd4: begin
											rec.op_class = OP_INC_R8;
											rec.dst_code = r_field;
										end
										3'd5: begin
											rec.op_class = OP_DEC_R8;
											rec.dst_code = r_field;
										end
										3'd6: begin
											rec.op_class  = OP_LD_R8_IMM8;
											rec.imm_bytes = 2'd1;
											rec.dst_code  = r_field;
										end
										// Only the conditional relative jumps are left here.
										default: begin
											rec.op_class  = OP_JR_COND;
											rec.imm_bytes = 2'd1;
											rec.cond_code = r_field[1:0];
										end
									endcase
								end
							endcase
						end
					endcase
				end
				2'd1: begin
					if (opcode == OPC_HALT) begin
						rec.op_class = OP_HALT;
					end else begin
						rec.op_class = OP_LD_R8_R8;
						rec.dst_code = r_field;
						rec.src_code = z_field;
					end
				end
				2'd2: begin
					rec.op_class = OP_ALU_A_R8;
					rec.alu_kind = r_field;
					rec.src_code = z_field;
				end
				default: begin
					case (opcode) inside
						8'hC9: rec.op_class = OP_RET;
						8'hD9: rec.op_class = OP_RETI;
						8'hC3: begin
							rec.op_class  = OP_JP;
							rec.imm_bytes = 2'd2;
						end
						8'hE9: rec.op_class = OP_JP_HL;
						8'hCD: begin
							rec.op_class  = OP_CALL;
							rec.imm_bytes = 2'd2;
						end
						OPC_PREFIX: rec.op_class = OP_PREFIX;
						8'hE2: rec.op_class = OP_LDH_C_A;
						8'hE0: begin
							rec.op_class  = OP_LDH_IMM8_A;
							rec.imm_bytes = 2'd1;
						end
						8'hEA: begin
							rec.op_class  = OP_LD_IMM16_A;
							rec.imm_bytes = 2'd2;
						end
						8'hF2: rec.op_class = OP_LDH_A_C;
						8'hF0: begin
							rec.op_class  = OP_LDH_A_IMM8;
							rec.imm_bytes = 2'd1;
						end
						8'hFA: begin
							rec.op_class  = OP_LD_A_IMM16;
							rec.imm_bytes = 2'd2;
						end
						8'hE8: begin
							rec.op_class  = OP_ADD_SP_E8;
							rec.imm_bytes = 2'd1;
						end
						8'hF8: begin
							rec.op_class  = OP_LD_HL_SP_E8;
							rec.imm_bytes = 2'd1;
						end
						8'hF9: rec.op_class = OP_LD_SP_HL;
						8'hF3: rec.op_class = OP_DI;
						8'hFB: rec.op_class = OP_EI;
						8'hD3, 8'hDB, 8'hDD, 8'hE3, 8'hE4, 8'hEB,
						8'hEC, 8'hED, 8'hF4, 8'hFC, 8'hFD: begin
							rec.op_class = OP_ILLEGAL;
							rec.illegal  = 1'b1;
						end
						default: begin
							case (z_field)
								3'd0: begin
									rec.op_class  = OP_RET_COND;
									rec.cond_code = r_field[1:0];
								end
								3'd1: begin
									rec.op_class  = OP_POP;
									rec.pair_code = p_field;
								end
								3'd2: begin
									rec.op_class  = OP_JP_COND;
									rec.imm_bytes = 2'd2;
									rec.cond_code = r_field[1:0];
								end
								3'd4: begin
									rec.op_class  = OP_CALL_COND;
									rec.imm_bytes = 2'd2;
									rec.cond_code = r_field[1:0];
								end
								3'd5: begin
									rec.op_class  = OP_PUSH;
									rec.pair_code = p_field;
								end
								3'd6: begin
									rec.op_class  = OP_ALU_A_IMM8;
									rec.imm_bytes = 2'd1;
									rec.alu_kind  = r_field;
								end
								3'd7: begin
									rec.op_class       = OP_RST;
									rec.restart_vector = {r_field, 3'b000};
								end
								// Every opcode ending in 3 is matched above.
								default: begin
									rec.op_class = OP_ILLEGAL;
									rec.illegal  = 1'b1;
								end
							endcase
						end
					endcase
				end
			endcase
		end
	end

endmodule

// File: rtl/cpu_opcode_decoder.sv
// ----------------------------------------------------------------------------
// cpu_opcode_decoder
// Instruction decoder for an 8-bit CPU core: one opcode byte in, one decoded
// record out, with an input register and a result register around the logic.
//
//   Channel  Handshake                  Payload
//   fetch    fetch_valid / fetch_stall  opcode, after_prefix
//   decode   decode_valid / decode_stall op_class ... illegal
//
// One beat per cycle is accepted and delivered while decode_stall is low.
// The rate is set by the single decode pass between the two registers.
// Reset clears both stage valid bits; payload registers are not reset.
// A stall on the decode side holds the result. When the input stage also holds
// a beat, fetch_stall rises in that same cycle; with the input stage empty, one
// more beat is taken first.
// ----------------------------------------------------------------------------
module cpu_opcode_decoder
	import cod_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       fetch_valid,
	output logic       fetch_stall,
	input  logic [7:0] opcode,
	input  logic       after_prefix,

	output logic       decode_valid,
	input  logic       decode_stall,
	output logic [5:0] op_class,
	output logic [2:0] alu_kind,
	output logic [2:0] dst_code,
	output logic [2:0] src_code,
	output logic [1:0] pair_code,
	output logic [1:0] cond_code,
	output logic [2:0] bit_number,
	output logic [5:0] restart_vector,
	output logic [1:0] imm_bytes,
	output logic       illegal
);

	logic       valid_s1;
	logic [7:0] opcode_s1;
	logic       after_prefix_s1;
	logic       valid_s2;
	cod_rec_t   rec_s2;
	cod_rec_t   rec_dec;
	logic       adv_s2;
	logic       adv_s1;

	// The result register moves when it is empty or its beat is taken.
	assign adv_s2      = !valid_s2 || !decode_stall;
	assign fetch_stall = valid_s1 && !adv_s2;
	assign adv_s1      = !fetch_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= fetch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && fetch_valid) begin
			opcode_s1       <= opcode;
			after_prefix_s1 <= after_prefix;
		end
	end

	cod_decode u_decode (
		.opcode       (opcode_s1),
		.after_prefix (after_prefix_s1),
		.rec          (rec_dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rec_s2 <= rec_dec;
		end
	end

	assign decode_valid   = valid_s2;
	assign op_class       = rec_s2.op_class;
	assign alu_kind       = rec_s2.alu_kind;
	assign dst_code       = rec_s2.dst_code;
	assign src_code       = rec_s2.src_code;
	assign pair_code      = rec_s2.pair_code;
	assign cond_code      = rec_s2.cond_code;
	assign bit_number     = rec_s2.bit_number;
	assign restart_vector = rec_s2.restart_vector;
	assign imm_bytes      = rec_s2.imm_bytes;
	assign illegal        = rec_s2.illegal;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_stall |-> valid_s1)
		else $error("fetch_stall raised with an empty input stage");

	a_item_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("decoded beat lost between stages");

	a_illegal_class: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && illegal) |-> (rec_s2.op_class == OP_ILLEGAL))
		else $error("illegal flag without the illegal class");

	a_imm_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (imm_bytes != 2'd3))
		else $error("immediate byte count out of range");

	a_rst_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (restart_vector[2:0] == 3'd0))
		else $error("restart vector not a multiple of eight");
`endif

endmodule
